/* rtl/core/bjec_pkg.sv */
// shared types and constants for the block jump exit counter
package bjec_pkg;

  // field widths of the stream items and the length register
  localparam int unsigned POS_W  = 10;
  localparam int unsigned JUMP_W = 11;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned CNT_W  = 11;

  // action codes carried in tuser
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // fraction bits of the block-size reciprocal used to find a block start
  localparam int unsigned RECIP_SH = 20;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;       // capture the accepted transaction
    logic jump_wr;       // store the new jump length
    logic base_en;       // register the block start
    logic last_en;       // register the last rebuilt position, load the index
    logic jump_rd;       // read the jump length at the index
    logic jump_rd_next;  // read the jump length at index minus one instead
    logic exit_rd_nt;    // read the exit entry at the jump landing
    logic exit_wr;       // write the exit entry at the index
    logic i_dec;         // step the index down
    logic walk_init;     // start a query walk at the start position
    logic walk_step;     // take one block exit
    logic out_load;      // move the count into the output register
  } bjec_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic pos_oob;     // write position outside the table
    logic blk_skip;    // block lies fully beyond the length
    logic i_at_start;  // index reached the block start
    logic q_skip;      // query starts at or beyond the length
    logic walk_stop;   // exit target does not advance
    logic walk_exit;   // exit target reaches or passes the length
    logic out_busy;    // output register still holds an untaken result
  } bjec_status_t;

endpackage

/* rtl/core/block_jump_exit_counter_unit.sv */
// top level of the block jump exit counter: stream ports, controller and datapath
// write transaction: stores the jump, registers the block start, then rebuilds the block's exits
//   backward from its last position in use through a jump-then-exit memory read chain
// query transaction: takes block exits (at most DEPTH/BLOCK) in an exit memory read loop;
//   one transaction is in work at a time
// a finished count waits in the output register while the next transaction is accepted
// reset: length register reads 1, controller idle, no result pending; memories are not cleared
module block_jump_exit_counter_unit
  import bjec_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned BLOCK = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // length register
  input  logic              cfg_we_i,
  input  logic [LEN_W-1:0]  cfg_wdata_i,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,   // [9:0] position, [20:10] jump_length, rest zero
  input  logic [0:0]        s_axis_tuser,   // [0] action: write or query
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata    // [10:0] jump_count, rest zero
);

  bjec_cmd_t        cmd;
  bjec_status_t     st;
  logic [CNT_W-1:0] count;

  // controller only sees the action bit, payload goes straight to the datapath
  bjec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser[0]),
    .in_ready_o  (s_axis_tready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // memories, block start arithmetic, rebuild index and walk accumulator
  bjec_dp #(
    .DEPTH (DEPTH),
    .BLOCK (BLOCK)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_pos_i    (s_axis_tdata[POS_W-1:0]),
    .in_jump_i   (s_axis_tdata[POS_W+JUMP_W-1:POS_W]),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_count_o (count)
  );

  // pad the count to whole bytes
  assign m_axis_tdata = {(16 - CNT_W)'(0), count};

endmodule

/* rtl/core/bjec_ram.sv */
// generic single-write, single-read memory with registered read data
module bjec_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/bjec_ctrl.sv */
// controller state machine sequencing writes, block rebuilds and query walks
module bjec_ctrl
  import bjec_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_action_i,
  output logic         in_ready_o,
  input  bjec_status_t st_i,
  output bjec_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_W_WRITE = 4'd1;
  localparam logic [3:0] S_W_BASE  = 4'd2;
  localparam logic [3:0] S_W_LAST  = 4'd3;
  localparam logic [3:0] S_R_PRIME = 4'd4;
  localparam logic [3:0] S_R_A     = 4'd5;
  localparam logic [3:0] S_R_B     = 4'd6;
  localparam logic [3:0] S_Q_START = 4'd7;
  localparam logic [3:0] S_Q_WALK  = 4'd8;
  localparam logic [3:0] S_Q_DONE  = 4'd9;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = (in_action_i == ACT_QUERY) ? S_Q_START : S_W_WRITE;
        end
      end
      S_W_WRITE: begin
        cmd_o.jump_wr = 1'b1;
        state_d = st_i.pos_oob ? S_IDLE : S_W_BASE;
      end
      S_W_BASE: begin
        cmd_o.base_en = 1'b1;
        state_d = S_W_LAST;
      end
      S_W_LAST: begin
        if (st_i.blk_skip) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.last_en = 1'b1;
          state_d = S_R_PRIME;
        end
      end
      S_R_PRIME: begin
        cmd_o.jump_rd = 1'b1;
        state_d = S_R_A;
      end
      S_R_A: begin
        // landing computed, its exit entry fetched, next jump prefetched
        cmd_o.exit_rd_nt   = 1'b1;
        cmd_o.jump_rd      = 1'b1;
        cmd_o.jump_rd_next = 1'b1;
        state_d = S_R_B;
      end
      S_R_B: begin
        cmd_o.exit_wr = 1'b1;
        if (st_i.i_at_start) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.i_dec = 1'b1;
          state_d = S_R_A;
        end
      end
      S_Q_START: begin
        cmd_o.walk_init = 1'b1;
        state_d = st_i.q_skip ? S_Q_DONE : S_Q_WALK;
      end
      S_Q_WALK: begin
        if (st_i.walk_stop) begin
          state_d = S_Q_DONE;
        end else begin
          cmd_o.walk_step = 1'b1;
          if (st_i.walk_exit) begin
            state_d = S_Q_DONE;
          end
        end
      end
      S_Q_DONE: begin
        if (!st_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/bjec_dp.sv */
// datapath: jump and exit memories, block start, rebuild index, query walk, output register
module bjec_dp
  import bjec_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned BLOCK = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LEN_W-1:0]  cfg_wdata_i,
  input  logic [POS_W-1:0]  in_pos_i,
  input  logic [JUMP_W-1:0] in_jump_i,
  input  bjec_cmd_t         cmd_i,
  output bjec_status_t      st_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [CNT_W-1:0]  out_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned TW = $clog2(DEPTH + 1);
  localparam int unsigned SW = $clog2(BLOCK + 1);
  localparam int unsigned EW = SW + TW;
  localparam int unsigned XW = ((TW > LEN_W) ? TW : LEN_W) + 1;
  localparam int unsigned PW = POS_W + RECIP_SH;
  localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'((1 << RECIP_SH) / BLOCK);

  logic [LEN_W-1:0]  len_q;
  logic [POS_W-1:0]  pos_q;
  logic [JUMP_W-1:0] jump_q;
  logic [POS_W-1:0]  q0_q;
  logic [XW-1:0]     start_q, start_d;
  logic [XW-1:0]     last_q, last_d;
  logic [AW-1:0]     i_q;
  logic [XW-1:0]     nt_q, nt_d;
  logic [TW-1:0]     j_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  out_data_q;
  logic              out_valid_q;

  logic [PW-1:0]     prod;
  logic [XW-1:0]     base0, rem, len_x, len_eff, blk_end;
  logic [JUMP_W-1:0] jump_w;
  logic [AW-1:0]     jump_raddr, exit_raddr;
  logic [JUMP_W-1:0] jump_rdata;
  logic [EW-1:0]     exit_rdata, exit_wdata;
  logic [SW-1:0]     ex_steps, steps_w;
  logic [TW-1:0]     ex_tgt, tgt_w;
  logic              in_blk;
  logic [CNT_W:0]    sum;

  // length register, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_W'(1);
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  assign len_x   = XW'(len_q);
  assign len_eff = (len_x > XW'(DEPTH)) ? XW'(DEPTH) : len_x;

  // block start: reciprocal estimate, then one correction
  assign prod    = PW'(pos_q) * PW'(RECIP);
  assign base0   = XW'(q0_q) * XW'(BLOCK);
  assign rem     = XW'(pos_q) - base0;
  assign start_d = (rem >= XW'(BLOCK)) ? base0 + XW'(BLOCK) : base0;
  assign blk_end = start_q + XW'(BLOCK - 1);
  assign last_d  = (blk_end > len_eff - XW'(1)) ? len_eff - XW'(1) : blk_end;

  assign jump_w = (jump_q == '0) ? JUMP_W'(1) : jump_q;

  // rebuild: landing of the current jump and the exit entry it inherits
  assign nt_d     = XW'(i_q) + XW'(jump_rdata);
  assign ex_steps = exit_rdata[EW-1:TW];
  assign ex_tgt   = exit_rdata[TW-1:0];
  assign in_blk   = (nt_q <= last_q);
  assign steps_w  = in_blk ? SW'(ex_steps + SW'(1)) : SW'(1);
  assign tgt_w    = in_blk ? ex_tgt
                  : ((nt_q > XW'(DEPTH)) ? TW'(DEPTH) : nt_q[TW-1:0]);
  assign exit_wdata = {steps_w, tgt_w};

  assign jump_raddr = cmd_i.jump_rd_next ? AW'(i_q - AW'(1)) : i_q;

  always_comb begin
    if (cmd_i.walk_init) begin
      exit_raddr = AW'(pos_q);
    end else if (cmd_i.walk_step) begin
      exit_raddr = AW'(ex_tgt);
    end else if (nt_d <= last_q) begin
      exit_raddr = AW'(nt_d);
    end else begin
      exit_raddr = i_q;
    end
  end

  // saturating count of the walk
  assign sum = {1'b0, cnt_q} + (CNT_W + 1)'(ex_steps);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      pos_q  <= in_pos_i;
      jump_q <= in_jump_i;
    end
    q0_q <= prod[PW-1:RECIP_SH];
    if (cmd_i.base_en) begin
      start_q <= start_d;
    end
    if (cmd_i.last_en) begin
      last_q <= last_d;
      i_q    <= last_d[AW-1:0];
    end else if (cmd_i.i_dec) begin
      i_q <= i_q - AW'(1);
    end
    if (cmd_i.exit_rd_nt) begin
      nt_q <= nt_d;
    end
    if (cmd_i.walk_init) begin
      j_q   <= TW'(pos_q);
      cnt_q <= '0;
    end else if (cmd_i.walk_step) begin
      j_q   <= ex_tgt;
      cnt_q <= sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_data_q <= cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  bjec_ram #(
    .WIDTH (JUMP_W),
    .DEPTH (DEPTH)
  ) u_jump_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.jump_wr && !st_o.pos_oob),
    .waddr_i (AW'(pos_q)),
    .wdata_i (jump_w),
    .re_i    (cmd_i.jump_rd),
    .raddr_i (jump_raddr),
    .rdata_o (jump_rdata)
  );

  bjec_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_exit_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exit_wr),
    .waddr_i (i_q),
    .wdata_i (exit_wdata),
    .re_i    (cmd_i.walk_init || cmd_i.walk_step || cmd_i.exit_rd_nt),
    .raddr_i (exit_raddr),
    .rdata_o (exit_rdata)
  );

  assign st_o.pos_oob    = (XW'(pos_q) >= XW'(DEPTH));
  assign st_o.blk_skip   = (len_eff == '0) || (start_q >= len_eff);
  assign st_o.i_at_start = (XW'(i_q) == start_q);
  assign st_o.q_skip     = (XW'(pos_q) >= len_eff);
  assign st_o.walk_stop  = (ex_tgt <= j_q);
  assign st_o.walk_exit  = (XW'(ex_tgt) >= len_eff);
  assign st_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_count_o = out_data_q;

endmodule

/* tb/block_jump_exit_counter_unit_tb.sv */
// self-checking testbench for the block jump exit counter: table-driven and random stream traffic
module block_jump_exit_counter_unit_tb
  import bjec_pkg::*;
();

  // block geometry, matches the defaults of the unit
  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned BLOCK       = 32;
  localparam int unsigned COUNT_SAT   = 2047;
  // quiet cycles after the last result before a length change or the end;
  // a full-block rebuild produces no result, so the quiet time lets it finish
  localparam int unsigned SETTLE      = 80;
  // cycles without any transaction before the run is declared hung
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned NUM_PROBES  = 15;
  localparam int unsigned NUM_PHASES  = 12;
  localparam int unsigned PHASE_ITEMS = 14;
  localparam int unsigned MAX_SHOWN   = 10;

  // one row of the directed table; count is typed in only when known is set
  typedef struct packed {
    logic              act;
    logic [POS_W-1:0]  pos;
    logic [JUMP_W-1:0] jmp;
    logic              known;
    logic [CNT_W-1:0]  count;
  } probe_row_t;

  // all inputs of the unit start at known values
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [LEN_W-1:0]  cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata  = '0;  // [9:0] position, [20:10] jump_length, rest zero
  logic [0:0]        s_axis_tuser  = '0;  // [0] action: write or query
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;        // [10:0] jump_count, rest zero

  // shadow copy of the unit: jump table, per-position block exits, length register
  logic [JUMP_W-1:0] jump_mem   [DEPTH];
  logic [5:0]        hop_mem    [DEPTH];
  logic [LEN_W-1:0]  land_mem   [DEPTH];
  bit                jump_known [DEPTH];
  bit                exit_known [DEPTH];
  logic [LEN_W-1:0]  length_reg = 11'd1;

  // jump counts still owed by the unit, oldest first
  logic [CNT_W-1:0]  pending_counts [$];

  int unsigned fail_count    = 0;
  int unsigned writes_sent   = 0;
  int unsigned queries_sent  = 0;
  int unsigned counts_seen   = 0;
  int unsigned lengths_tried = 0;
  int unsigned quiet_cycles  = 0;
  // when set, neither side leaves gaps
  bit          steady        = 1'b0;

  block_jump_exit_counter_unit #(
    .DEPTH (DEPTH),
    .BLOCK (BLOCK)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 unit period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow model
  // ---------------------------------------------------------------------------

  // lengths above the table behave as the full table
  function automatic int unsigned live_length();
    return (length_reg > DEPTH) ? DEPTH : int'(length_reg);
  endfunction

  // recompute exits of one block, from its last position in use back to its first
  function automatic void rebuild_exits(input int unsigned start);
    int unsigned len;
    int unsigned last;
    int unsigned nt;
    int          i;
    len = live_length();
    if (len == 0 || start >= len) return;
    last = start + BLOCK - 1;
    if (last > len - 1) last = len - 1;
    for (i = int'(last); i >= int'(start); i--) begin
      nt = i + jump_mem[i];
      if (nt <= last) begin
        // landing stays inside the block: chain onto its exit
        hop_mem[i]  = hop_mem[nt] + 6'd1;
        land_mem[i] = land_mem[nt];
      end else begin
        // one jump leaves the block, landing past the table is clipped
        hop_mem[i]  = 6'd1;
        land_mem[i] = (nt > DEPTH) ? LEN_W'(DEPTH) : LEN_W'(nt);
      end
      exit_known[i] = 1'b1;
    end
  endfunction

  // a write stores the jump (zero acts as one) and rebuilds its block
  function automatic void store_jump(input logic [POS_W-1:0] pos, input logic [JUMP_W-1:0] jmp);
    jump_mem[pos]   = (jmp == '0) ? JUMP_W'(1) : jmp;
    jump_known[pos] = 1'b1;
    rebuild_exits(pos - (pos % BLOCK));
  endfunction

  // a query follows block exits until the length is reached or a target fails to advance
  function automatic logic [CNT_W-1:0] walk_count(input logic [POS_W-1:0] pos);
    int unsigned len;
    int unsigned j;
    int unsigned total;
    len   = live_length();
    j     = pos;
    total = 0;
    while (j < len && land_mem[j] > j) begin
      total += hop_mem[j];
      if (total > COUNT_SAT) total = COUNT_SAT;
      j = land_mem[j];
    end
    return CNT_W'(total);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // short jumps and zero (stored as one) give long walks, long ones leave the block at once
  function automatic logic [JUMP_W-1:0] pick_jump();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return JUMP_W'($urandom_range(3, 1));
    if (r < 80) return JUMP_W'($urandom_range(40, 1));
    if (r < 95) return JUMP_W'($urandom_range(1024, 1));
    if (r < 98) return JUMP_W'(1024);
    return '0;
  endfunction

  // mostly inside the length, often near its end, sometimes anywhere
  function automatic logic [POS_W-1:0] pick_pos(input int unsigned eff);
    int unsigned r;
    int unsigned span;
    r = $urandom_range(99);
    if (eff == 0 || r < 15) return POS_W'($urandom_range(DEPTH - 1));
    if (r < 40) begin
      span = (eff - 1 < 40) ? eff - 1 : 40;
      return POS_W'(eff - 1 - $urandom_range(span));
    end
    return POS_W'($urandom_range(eff - 1));
  endfunction

  // directed table, run right after reset with the length at its reset value of one
  function automatic probe_row_t probe_row(input int unsigned idx);
    case (idx)
      // start at or beyond the length returns zero
      0:  return '{ACT_QUERY, 10'd1023, 11'd0,    1'b1, 11'd0};
      1:  return '{ACT_QUERY, 10'd1,    11'd2047, 1'b1, 11'd0};
      // zero jump is stored as one
      2:  return '{ACT_WRITE, 10'd0,    11'd0,    1'b0, 11'd0};
      3:  return '{ACT_QUERY, 10'd0,    11'd0,    1'b1, 11'd1};
      4:  return '{ACT_WRITE, 10'd0,    11'd1024, 1'b0, 11'd0};
      5:  return '{ACT_QUERY, 10'd0,    11'd0,    1'b1, 11'd1};
      // rebuild of block zero stops at length minus one
      6:  return '{ACT_WRITE, 10'd31,   11'd1,    1'b0, 11'd0};
      // block fully beyond the length: store only
      7:  return '{ACT_WRITE, 10'd1023, 11'd1024, 1'b0, 11'd0};
      8:  return '{ACT_WRITE, 10'd682,  11'd682,  1'b0, 11'd0};
      9:  return '{ACT_WRITE, 10'd341,  11'd341,  1'b0, 11'd0};
      10: return '{ACT_QUERY, 10'd682,  11'd0,    1'b1, 11'd0};
      11: return '{ACT_QUERY, 10'd341,  11'd0,    1'b1, 11'd0};
      12: return '{ACT_WRITE, 10'd0,    11'd1,    1'b0, 11'd0};
      13: return '{ACT_QUERY, 10'd0,    11'd0,    1'b1, 11'd1};
      default: return '{ACT_QUERY, 10'd31, 11'd0, 1'b0, 11'd0};
    endcase
  endfunction

  // length settings, extremes first, then a few random ones
  function automatic logic [LEN_W-1:0] phase_length(input int unsigned idx);
    case (idx)
      0:       return 11'd1024;
      1:       return 11'd2047;  // beyond the table
      2:       return 11'd50;    // partial last block
      3:       return 11'd0;     // nothing in use
      4:       return 11'd33;
      5:       return 11'd32;
      6:       return 11'd1;
      7:       return 11'd31;
      8:       return 11'd1023;
      9:       return 11'd700;
      default: return LEN_W'($urandom_range(1024, 2));
    endcase
  endfunction

  // offer one transaction after a random gap and hold it until accepted;
  // tvalid stays high on return so a back-to-back item needs no second assignment
  task automatic push_item(input logic act, input logic [POS_W-1:0] pos,
                           input logic [JUMP_W-1:0] jmp, input logic known,
                           input logic [CNT_W-1:0] count);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {3'b000, jmp, pos};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    // accepted at this edge: update the shadow in order
    if (act == ACT_QUERY) begin
      pending_counts.push_back(known ? count : walk_count(pos));
      queries_sent++;
    end else begin
      store_jump(pos, jmp);
      writes_sent++;
    end
  endtask

  // length changes only with the unit idle: no result owed, last rebuild done
  task automatic set_length(input logic [LEN_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    length_reg  = value;
    lengths_tried++;
  endtask

  // one length setting: bring every block in use up to date, probe the edges, then random traffic
  task automatic run_phase(input logic [LEN_W-1:0] new_len, input int unsigned items);
    int unsigned eff;
    int unsigned base;
    int unsigned top;
    int unsigned p;
    bit          stale;
    set_length(new_len);
    eff = live_length();
    // blocks whose exits were never built get one write so every walk reads built entries
    for (base = 0; base < eff; base += BLOCK) begin
      top   = (base + BLOCK > eff) ? eff : base + BLOCK;
      stale = 1'b0;
      for (p = base; p < top; p++) if (!exit_known[p]) stale = 1'b1;
      if (stale) push_item(ACT_WRITE, POS_W'(base + $urandom_range(BLOCK - 1)), pick_jump(),
                           1'b0, '0);
    end
    if (eff != 0) begin
      // longest jump from the last position lands past the table
      push_item(ACT_WRITE, POS_W'(eff - 1), 11'd1024, 1'b0, '0);
      push_item(ACT_QUERY, 10'd0, '0, 1'b0, '0);
      push_item(ACT_QUERY, POS_W'(eff - 1), '0, 1'b0, '0);
    end
    if (eff < DEPTH) push_item(ACT_QUERY, POS_W'($urandom_range(DEPTH - 1, eff)), '0, 1'b0, '0);
    repeat (items) begin
      if (eff != 0 && $urandom_range(99) < 15) begin
        // rework one block, then walk from its start
        base = $urandom_range((eff - 1) / BLOCK) * BLOCK;
        repeat ($urandom_range(6, 3))
          push_item(ACT_WRITE, POS_W'(base + $urandom_range(BLOCK - 1)), pick_jump(), 1'b0, '0);
        push_item(ACT_QUERY, POS_W'(base), pick_jump(), 1'b0, '0);
      end else if ($urandom_range(99) < 45) begin
        push_item(ACT_WRITE, pick_pos(eff), pick_jump(), 1'b0, '0);
      end else begin
        push_item(ACT_QUERY, pick_pos(eff), pick_jump(), 1'b0, '0);
      end
    end
  endtask

  task automatic note_fault(input string what, input logic [CNT_W-1:0] want,
                            input logic [CNT_W-1:0] got);
    fail_count++;
    if (fail_count <= MAX_SHOWN)
      $display("%0t: %s: jump_count expected %0d, got %0d", $time, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    probe_row_t  row;
    int unsigned k;
    // single reset at the start of the run
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at the reset length of one
    for (k = 0; k < NUM_PROBES; k++) begin
      row = probe_row(k);
      push_item(row.act, row.pos, row.jmp, row.known, row.count);
    end

    // fill the rest of the jump table while the length is one, so rebuilds only touch
    // position zero and no later rebuild reads an unwritten jump
    for (k = 0; k < DEPTH; k++)
      if (!jump_known[k]) push_item(ACT_WRITE, POS_W'(k), pick_jump(), 1'b0, '0);

    // length settings, every fourth one with no gaps on either side
    for (k = 0; k < NUM_PHASES; k++) begin
      steady = (k % 4 == 2);
      run_phase(phase_length(k), PHASE_ITEMS);
    end

    // drain and let the last rebuild finish
    s_axis_tvalid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("run covered %0d writes and %0d queries over %0d length settings",
             writes_sent, queries_sent, lengths_tried);
    $display("%0d jump counts compared, %0d mismatches", counts_seen, fail_count);
    if (fail_count == 0 && pending_counts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random backpressure and the check against the oldest expectation
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned      stall;
    logic [CNT_W-1:0] got;
    logic [CNT_W-1:0] want;
    wait (rst_ni === 1'b1);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      // transaction at this edge
      got = m_axis_tdata[CNT_W-1:0];
      counts_seen++;
      if (pending_counts.size() == 0) begin
        note_fault("result with no query waiting", '0, got);
      end else begin
        want = pending_counts.pop_front();
        if (got !== want) note_fault("wrong count", want, got);
      end
    end
  end

  // watchdog: any transaction or register write restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d counts owed",
               QUIET_LIMIT, pending_counts.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

/* filelist.f */
rtl/core/bjec_pkg.sv
rtl/core/bjec_ram.sv
rtl/core/bjec_ctrl.sv
rtl/core/bjec_dp.sv
rtl/core/block_jump_exit_counter_unit.sv
tb/block_jump_exit_counter_unit_tb.sv
